[design/tcas_pkg.sv]
package tcas_pkg;

  localparam int KIND_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 11;
  localparam int NIB_W      = 4;
  localparam int COLOR_W    = 8;
  localparam int CURSOR_W   = 11;
  localparam int CELL_W     = CHAR_W + COLOR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CHAR_W-1:0] NEWLINE = 8'h0A;

  localparam logic [NIB_W-1:0]   TEXT_FG_RST    = 4'd2;
  localparam logic [NIB_W-1:0]   TEXT_BG_RST    = 4'd0;
  localparam logic [CHAR_W-1:0]  FILL_CHAR_RST  = 8'h41;
  localparam logic [COLOR_W-1:0] FILL_COLOR_RST = 8'h00;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_READ   = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEXT_FG    = 2'd0,
    CFG_TEXT_BG    = 2'd1,
    CFG_FILL_CHAR  = 2'd2,
    CFG_FILL_COLOR = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_CHECK,
    S_SCROLL,
    S_FILL,
    S_PUT,
    S_RDWAIT,
    S_DONE
  } state_t;

endpackage

[design/tcas_ram.sv]
module tcas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/text_console_append_scroll.sv]
// channel | direction | ports                                            | word accepted
// in      | input     | in_valid/in_ready, kind, char_code, index, fg, bg | valid & ready
// out     | output    | out_valid/out_ready, read char/color, cursor, scroll | valid & ready
// cfg     | input     | cfg_valid/cfg_ready, cfg_index, cfg_data          | valid & ready
//
// one word at a time: append EXEC,CHECK,PUT,DONE; write EXEC,DONE; read EXEC,RDWAIT,DONE
// an append that scrolls adds SCROLL and FILL: a read counter feeds a write counter that
// walks every cell once through the one read and one write port of the store
// after reset the store is cleared one cell a cycle, in_ready low
// the result waits in its register until taken; cfg is always ready
module text_console_append_scroll #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tcas_pkg::KIND_W-1:0]         in_kind,
  input  logic [tcas_pkg::CHAR_W-1:0]         in_char_code,
  input  logic [tcas_pkg::IDX_W-1:0]          in_cell_index,
  input  logic [tcas_pkg::NIB_W-1:0]          in_cell_fg,
  input  logic [tcas_pkg::NIB_W-1:0]          in_cell_bg,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tcas_pkg::CHAR_W-1:0]         out_read_char,
  output logic [tcas_pkg::COLOR_W-1:0]        out_read_color,
  output logic [tcas_pkg::CURSOR_W-1:0]       out_cursor_now,
  output logic                                out_did_scroll,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tcas_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcas_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import tcas_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CUR_W = $clog2(CELLS + COLUMNS + 1);
  localparam int COL_W = $clog2(COLUMNS);
  localparam int CMP_W = (CUR_W > IDX_W) ? CUR_W : IDX_W;

  state_t state_r, state_nxt;

  logic [CUR_W-1:0] cur_r, cur_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [CUR_W-1:0] src_r, src_nxt;
  logic [AW-1:0]    dst_r, dst_nxt;
  logic             pend_r, pend_nxt;

  logic [CHAR_W-1:0]  rchar_r, rchar_nxt;
  logic [COLOR_W-1:0] rcolor_r, rcolor_nxt;
  logic               scroll_r, scroll_nxt;

  logic [NIB_W-1:0]   text_fg_r, text_bg_r;
  logic [CHAR_W-1:0]  fill_char_r;
  logic [COLOR_W-1:0] fill_color_r;

  logic [KIND_W-1:0] kind_r;
  logic [CHAR_W-1:0] char_r;
  logic [IDX_W-1:0]  idx_r;
  logic [NIB_W-1:0]  fg_r, bg_r;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  logic in_accept, idx_ok, is_newline, issuing;

  assign in_accept  = in_valid && in_ready;
  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = (state_r == S_DONE);
  assign cfg_ready  = 1'b1;
  assign idx_ok     = CMP_W'(idx_r) < CMP_W'(CELLS);
  assign is_newline = (char_r == NEWLINE);
  assign issuing    = (src_r != CUR_W'(CELLS));

  assign out_read_char  = rchar_r;
  assign out_read_color = rcolor_r;
  assign out_cursor_now = CURSOR_W'(cur_r);
  assign out_did_scroll = scroll_r;

  tcas_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cur_r        <= '0;
      col_r        <= '0;
      src_r        <= '0;
      dst_r        <= '0;
      pend_r       <= 1'b0;
      scroll_r     <= 1'b0;
      text_fg_r    <= TEXT_FG_RST;
      text_bg_r    <= TEXT_BG_RST;
      fill_char_r  <= FILL_CHAR_RST;
      fill_color_r <= FILL_COLOR_RST;
    end else begin
      state_r  <= state_nxt;
      cur_r    <= cur_nxt;
      col_r    <= col_nxt;
      src_r    <= src_nxt;
      dst_r    <= dst_nxt;
      pend_r   <= pend_nxt;
      scroll_r <= scroll_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_TEXT_FG:    text_fg_r    <= cfg_data[NIB_W-1:0];
          CFG_TEXT_BG:    text_bg_r    <= cfg_data[NIB_W-1:0];
          CFG_FILL_CHAR:  fill_char_r  <= cfg_data[CHAR_W-1:0];
          CFG_FILL_COLOR: fill_color_r <= cfg_data[COLOR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload words
  always_ff @(posedge clk) begin
    rchar_r  <= rchar_nxt;
    rcolor_r <= rcolor_nxt;
    if (in_accept) begin
      kind_r <= in_kind;
      char_r <= in_char_code;
      idx_r  <= in_cell_index;
      fg_r   <= in_cell_fg;
      bg_r   <= in_cell_bg;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    col_nxt    = col_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    pend_nxt   = 1'b0;
    scroll_nxt = scroll_r;
    rchar_nxt  = rchar_r;
    rcolor_nxt = rcolor_r;
    ram_we     = 1'b0;
    ram_waddr  = dst_r;
    ram_wdata  = '0;
    ram_raddr  = AW'(idx_r);

    case (state_r)
      S_CLEAR: begin
        ram_we  = 1'b1;
        dst_nxt = dst_r + 1'b1;
        if (dst_r == AW'(CELLS - 1)) begin
          dst_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        rchar_nxt  = '0;
        rcolor_nxt = '0;
        scroll_nxt = 1'b0;
        case (kind_t'(kind_r))
          KIND_APPEND: begin
            if (is_newline) begin
              cur_nxt = cur_r + CUR_W'(COLUMNS) - CUR_W'(col_r);
              col_nxt = '0;
            end
            state_nxt = S_CHECK;
          end
          KIND_WRITE: begin
            ram_we    = idx_ok;
            ram_waddr = AW'(idx_r);
            ram_wdata = {char_r, bg_r, fg_r};
            state_nxt = S_DONE;
          end
          KIND_READ: begin
            state_nxt = S_RDWAIT;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_CHECK: begin
        if (cur_r >= CUR_W'(CELLS)) begin
          scroll_nxt = 1'b1;
          src_nxt    = CUR_W'(COLUMNS);
          dst_nxt    = '0;
          state_nxt  = S_SCROLL;
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_SCROLL: begin
        // read one row below, write the word back in the cycle after
        ram_raddr = AW'(src_r);
        if (issuing) begin
          src_nxt  = src_r + 1'b1;
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          dst_nxt   = dst_r + 1'b1;
        end
        if (!issuing && !pend_r) begin
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = {fill_char_r, fill_color_r};
        dst_nxt   = dst_r + 1'b1;
        if (dst_r == AW'(CELLS - 1)) begin
          dst_nxt   = '0;
          cur_nxt   = cur_r - CUR_W'(COLUMNS);
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        if (!is_newline && (cur_r < CUR_W'(CELLS))) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(cur_r);
          ram_wdata = {char_r, text_bg_r, text_fg_r};
          cur_nxt   = cur_r + 1'b1;
          col_nxt   = (col_r == COL_W'(COLUMNS - 1)) ? '0 : col_r + 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_RDWAIT: begin
        if (idx_ok) begin
          rchar_nxt  = ram_rdata[CELL_W-1:COLOR_W];
          rcolor_nxt = ram_rdata[COLOR_W-1:0];
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cur_r <= CUR_W'(CELLS)))
    else $error("cursor beyond screen end while idle");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_W'(COLUMNS - 1))
    else $error("column counter out of range");

  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_did_scroll) |-> (cur_r >= CUR_W'(CELLS - COLUMNS)))
    else $error("cursor not on bottom row after scroll");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && in_ready))
    else $error("input taken while result pending");

endmodule
